// ===== hw/rtl/index_allocator_with_recycle_top_assert.svh =====
// Assertion macros for the index allocator.
// Each macro expects aclk and aresetn in scope.
`ifndef INDEX_ALLOCATOR_WITH_RECYCLE_TOP_ASSERT_SVH
`define INDEX_ALLOCATOR_WITH_RECYCLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define IAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define IAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iar_pkg.sv =====
package iar_pkg;

    localparam int IDX_W = 32;
    localparam int OP_W  = 2;

    localparam int STASH_DEPTH_DEF = 64;
    localparam int RSV_DEPTH_DEF   = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RECYCLE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

    // Status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // Request to the reserved-list scanner
    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] candidate;
    } scan_req_t;

    // Scanner answer: done pulses once, hit tells whether candidate is reserved
    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

endpackage

// ===== hw/rtl/iar_stash.sv =====
module iar_stash import iar_pkg::*; #(
    parameter int DEPTH = STASH_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_en,
    input  logic [IDX_W-1:0] push_data,
    input  logic             pop_en,
    output logic [IDX_W-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    top_idx;
    logic [IDX_W-1:0] rdata_reg;

    assign top_idx  = count_reg - CW'(1);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign pop_data = rdata_reg;

    // Advance the fill count on push or pop
    always_comb begin
        count_next = count_reg;
        if (push_en) begin
            count_next = count_reg + CW'(1);
        end else if (pop_en) begin
            count_next = top_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Write at the fill point, read the top entry on pop
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[count_reg[AW-1:0]] <= push_data;
        end
        if (pop_en) begin
            rdata_reg <= mem[top_idx[AW-1:0]];
        end
    end

endmodule

// ===== hw/rtl/iar_reserved.sv =====
module iar_reserved import iar_pkg::*; #(
    parameter int DEPTH = RSV_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_en,
    input  logic [IDX_W-1:0] push_data,
    output logic             full,
    input  scan_req_t        scan_req,
    output scan_rsp_t        scan_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    addr_reg,    addr_next;
    logic             issue_reg,   issue_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             cmp_last_reg, cmp_last_next;
    logic [IDX_W-1:0] cand_reg,    cand_next;
    logic [IDX_W-1:0] rdata_reg;
    logic             done_reg,    done_next;
    logic             hit_reg,     hit_next;
    logic             at_last;
    logic             match;

    assign full          = (count_reg == CW'(DEPTH));
    assign at_last       = (addr_reg == count_reg - CW'(1));
    assign match         = (rdata_reg == cand_reg);
    assign scan_rsp.done = done_reg;
    assign scan_rsp.hit  = hit_reg;

    // Append to the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (push_en) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // One read per cycle while issuing, data registered
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[count_reg[AW-1:0]] <= push_data;
        end
        if (issue_reg) begin
            rdata_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    // Scan sequencer: issue reads, compare each returned entry against the candidate
    always_comb begin
        addr_next     = addr_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = 1'b0;
        cmp_last_next = cmp_last_reg;
        cand_next     = cand_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;

        if (issue_reg) begin
            cmp_vld_next  = 1'b1;
            cmp_last_next = at_last;
            addr_next     = addr_reg + CW'(1);
            if (at_last) begin
                issue_next = 1'b0;
            end
        end

        if (cmp_vld_reg) begin
            if (match) begin
                done_next    = 1'b1;
                hit_next     = 1'b1;
                issue_next   = 1'b0;
                cmp_vld_next = 1'b0;
            end else if (cmp_last_reg) begin
                done_next = 1'b1;
                hit_next  = 1'b0;
            end
        end

        if (scan_req.start) begin
            cand_next    = scan_req.candidate;
            addr_next    = '0;
            cmp_vld_next = 1'b0;
            if (count_reg == '0) begin
                done_next  = 1'b1;
                hit_next   = 1'b0;
                issue_next = 1'b0;
            end else begin
                issue_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        cmp_last_reg <= cmp_last_next;
        cand_reg     <= cand_next;
        hit_reg      <= hit_next;
    end

endmodule

// ===== hw/rtl/index_allocator_with_recycle_top.sv =====
// Channel  Direction  Ports
// s_       in         s_valid, s_ready, s_op[1:0], s_index_value[31:0]
// m_       out        m_valid, m_ready, m_allocated_index[31:0], m_status
//
// Recycle, reserve and unused ops go straight to the result; allocate from the stash pops its top entry.
// Allocate from the counter scans the reserved list for the next counter value and steps on past
// each reserved candidate; the shared comparator checks one entry of the list per cycle.
// s_ready is high only while the sequencer is idle; a result held on m_ stalls the
// sequencer in its last state, so the next item waits until m_ready frees the output.
// Reset is synchronous, active low, and empties the stash and the reserved list.
module index_allocator_with_recycle_top import iar_pkg::*; #(
    parameter int STASH_DEPTH    = STASH_DEPTH_DEF,
    parameter int RESERVED_DEPTH = RSV_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_op,
    input  logic [IDX_W-1:0] s_index_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_allocated_index,
    output logic             m_status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_POP  = 5'b00010,
        ST_STEP = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t           state_reg,   state_next;
    logic [IDX_W-1:0] counter_reg, counter_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_st_reg,  res_st_next;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_idx_reg,   m_idx_next;
    logic             m_st_reg,    m_st_next;

    logic             accept;
    logic             out_free;
    logic             stash_push, stash_pop, stash_empty, stash_full;
    logic [IDX_W-1:0] stash_data;
    logic             rsv_push, rsv_full;
    scan_req_t        scan_req;
    scan_rsp_t        scan_rsp;

    assign s_ready           = (state_reg == ST_IDLE);
    assign accept            = s_valid && s_ready;
    assign out_free          = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_allocated_index = m_idx_reg;
    assign m_status          = m_st_reg;

    assign stash_push = accept && (s_op == OP_RECYCLE) && !stash_full;
    assign stash_pop  = accept && (s_op == OP_ALLOC) && !stash_empty;
    assign rsv_push   = accept && (s_op == OP_RESERVE) && !rsv_full;

    iar_stash #(
        .DEPTH(STASH_DEPTH)
    ) u_stash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (stash_push),
        .push_data(s_index_value),
        .pop_en   (stash_pop),
        .pop_data (stash_data),
        .empty    (stash_empty),
        .full     (stash_full)
    );

    iar_reserved #(
        .DEPTH(RESERVED_DEPTH)
    ) u_reserved (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (rsv_push),
        .push_data(s_index_value),
        .full     (rsv_full),
        .scan_req (scan_req),
        .scan_rsp (scan_rsp)
    );

    // Sequencer: decode on accept, try counter candidates until one is free
    always_comb begin
        state_next         = state_reg;
        counter_next       = counter_reg;
        res_idx_next       = res_idx_reg;
        res_st_next        = res_st_reg;
        m_valid_next       = m_valid_reg;
        m_idx_next         = m_idx_reg;
        m_st_next          = m_st_reg;
        scan_req.start     = 1'b0;
        scan_req.candidate = counter_reg + IDX_W'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_idx_next = '0;
                    res_st_next  = STAT_OK;
                    state_next   = ST_DONE;
                    if (s_op == OP_ALLOC) begin
                        state_next = stash_empty ? ST_STEP : ST_POP;
                    end else if (s_op == OP_RECYCLE) begin
                        res_st_next = stash_full ? STAT_FULL : STAT_OK;
                    end else if (s_op == OP_RESERVE) begin
                        res_st_next = rsv_full ? STAT_FULL : STAT_OK;
                    end
                end
            end
            ST_POP: begin
                res_idx_next = stash_data;
                state_next   = ST_DONE;
            end
            ST_STEP: begin
                counter_next   = counter_reg + IDX_W'(1);
                scan_req.start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    if (scan_rsp.hit) begin
                        state_next = ST_STEP;
                    end else begin
                        res_idx_next = counter_reg;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_st_next    = res_st_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        m_idx_reg   <= m_idx_next;
        m_st_reg    <= m_st_next;
    end

`include "index_allocator_with_recycle_top_assert.svh"

    `IAR_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "input taken while busy")
    `IAR_ASSERT_NOW(a_scan_done_in_scan, scan_rsp.done, state_reg == ST_SCAN,
        "scan answer outside scan state")
    `IAR_ASSERT_NOW(a_flag_without_index, m_valid && m_status, m_allocated_index == '0,
        "rejected push carries an index")
    `IAR_ASSERT_NOW(a_no_push_when_full, stash_push || rsv_push,
        !(stash_push && stash_full) && !(rsv_push && rsv_full), "push into a full store")

endmodule
